/* hdl/lru_victim_selector_core_assert.svh */
// Assertion macros for the LRU victim selector checker.
`ifndef LRU_VICTIM_SELECTOR_CORE_ASSERT_SVH
`define LRU_VICTIM_SELECTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LVS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lvs_pkg.sv */
package lvs_pkg;

    localparam int FIU_W     = 5;   // frames_in_use register width
    localparam int FIU_RESET = 16;  // frames_in_use after reset
    localparam int FIDX_W    = 4;   // frame index field width
    localparam int MASK_W    = 16;  // empty mask width

    typedef enum logic {
        OP_REFERENCE = 1'b0,
        OP_CHOOSE    = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [FIDX_W-1:0]  frame_index;
        logic [MASK_W-1:0]  empty_mask;
    } t_req;

    typedef struct packed {
        logic [FIDX_W-1:0]  victim_frame;
        logic               was_empty;
    } t_rsp;

endpackage

/* hdl/lvs_chan_if.sv */
interface lvs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

/* hdl/lvs_cd_mem.sv */
// Countdown store: one write and one registered read per cycle.
// Per-entry valid bits stand in for the reset value until an entry is written.
module lvs_cd_mem #(
    parameter int DEPTH       = 16,
    parameter int WIDTH       = 16,
    parameter int RESET_COUNT = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  logic signed [WIDTH-1:0]   i_wr_data,
    output logic signed [WIDTH-1:0]   o_rd_data
);
    localparam logic signed [WIDTH-1:0] RESET_VALUE = WIDTH'(RESET_COUNT);

    logic signed [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]        r_vld;
    logic signed [WIDTH-1:0] r_rd_data;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : RESET_VALUE;
endmodule

/* hdl/lru_victim_selector_core.sv */
// Channel   Dir  Handshake        Payload
// i_req     in   valid / ready    opcode, frame_index, empty_mask
// o_rsp     out  valid / ready    victim_frame, was_empty
// i_cfg_*   in   write enable     frames_in_use (5 bits)
//
// i_req.ready is low from accept until a reference or choose finishes; no new
// request is taken while one is in progress. One read port and one
// compare / saturating-decrement unit visit a frame per cycle; a choose stops
// at the first empty frame. Reset is synchronous; valid bits clear, no sweep.
// A finished choose waits in the output register while the next transaction
// runs; only a second choose result waits on o_rsp.ready.
module lru_victim_selector_core
    import lvs_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [FIU_W-1:0]  i_cfg_wdata,
    lvs_chan_if.sink          i_req,
    lvs_chan_if.source        o_rsp
);
    // frame index and frame counter widths
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    // countdowns come out of reset at the clamped reset frame count
    localparam int RESET_COUNT = (FIU_RESET > MAX_FRAMES) ? MAX_FRAMES : FIU_RESET;
    localparam logic signed [COUNT_BITS-1:0] COUNT_MIN =
        {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic signed [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    t_state                   r_state;
    logic [FIU_W-1:0]         r_fiu;
    t_opcode                  r_op;
    logic [FIDX_W-1:0]        r_fidx;
    logic [MASK_W-1:0]        r_mask;
    logic [CW-1:0]            r_ra;       // next frame to read
    logic                     r_pv;       // read data in flight is live
    logic [FW-1:0]            r_pi;       // frame whose data is in flight
    logic signed [COUNT_BITS-1:0] r_best;
    logic [FW-1:0]            r_pick;
    logic                     r_empty;
    logic                     r_out_valid;
    logic [FIDX_W-1:0]        r_out_frame;
    logic                     r_out_empty;

    logic [FIU_W-1:0]             w_n;
    logic signed [COUNT_BITS-1:0] w_refresh;
    logic signed [COUNT_BITS-1:0] w_cur;
    logic signed [COUNT_BITS-1:0] w_ref_val;
    logic signed [COUNT_BITS-1:0] w_dec;
    logic                         w_issue;
    logic                         w_last;
    logic                         w_hit;
    logic                         w_less;
    logic                         w_fin_go;
    logic [FIDX_W-1:0]            w_midx;
    logic                         w_wr_en;
    logic [FW-1:0]                w_wr_addr;
    logic signed [COUNT_BITS-1:0] w_wr_data;

    // effective frame count: 0 acts as 1, clamp at MAX_FRAMES
    always_comb begin
        priority if (r_fiu == '0) begin
            w_n = FIU_W'(1);
        end else if (int'(r_fiu) > MAX_FRAMES) begin
            w_n = FIU_W'(MAX_FRAMES);
        end else begin
            w_n = r_fiu;
        end
    end

    assign w_refresh = COUNT_BITS'(w_n);

    // read issue runs one frame ahead of processing
    assign w_issue = (r_state == ST_RUN) && (int'(r_ra) < int'(w_n));
    assign w_last  = r_pv && (int'(r_pi) == int'(w_n) - 1);

    // empty check: only the first 16 frames have mask bits
    assign w_midx = FIDX_W'(r_pi);
    assign w_hit  = (int'(r_pi) < MASK_W) && r_mask[w_midx];
    assign w_less = (w_cur < r_best);

    // reference: refresh the named frame, then saturating decrement
    assign w_ref_val = (int'(r_pi) == int'(r_fidx)) ? w_refresh : w_cur;
    assign w_dec     = (w_ref_val == COUNT_MIN) ? w_ref_val : w_ref_val - COUNT_ONE;

    // choose finishes once the output slot is free
    assign w_fin_go = (r_state == ST_FIN) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pi;
        w_wr_data = w_dec;
        if (r_state == ST_RUN && r_pv && r_op == OP_REFERENCE) begin
            w_wr_en = 1'b1;
        end else if (w_fin_go) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_pick;
            w_wr_data = w_refresh;
        end
    end

    lvs_cd_mem #(
        .DEPTH       (MAX_FRAMES),
        .WIDTH       (COUNT_BITS),
        .RESET_COUNT (RESET_COUNT)
    ) u_cd_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (FW'(r_ra)),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fiu       <= FIU_W'(FIU_RESET);
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fiu <= i_cfg_wdata;
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.payload.opcode;
                        r_fidx  <= i_req.payload.frame_index;
                        r_mask  <= i_req.payload.empty_mask;
                        r_ra    <= '0;
                        r_pv    <= 1'b0;
                        r_empty <= 1'b0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_pv <= w_issue;
                    r_pi <= FW'(r_ra);
                    if (w_issue) begin
                        r_ra <= r_ra + CW'(1);
                    end
                    if (r_pv) begin
                        if (r_op == OP_REFERENCE) begin
                            if (w_last) begin
                                r_state <= ST_IDLE;
                            end
                        end else if (w_hit) begin
                            // first empty frame wins outright
                            r_pick  <= r_pi;
                            r_empty <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            // strict less keeps the lowest index on ties
                            if (r_pi == '0 || w_less) begin
                                r_best <= w_cur;
                                r_pick <= r_pi;
                            end
                            if (w_last) begin
                                r_state <= ST_FIN;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    if (w_fin_go) begin
                        r_out_frame <= FIDX_W'(r_pick);
                        r_out_empty <= r_empty;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);

    assign o_rsp.valid                = r_out_valid;
    assign o_rsp.payload.victim_frame = r_out_frame;
    assign o_rsp.payload.was_empty    = r_out_empty;
endmodule

/* hdl/lvs_checker.sv */
`include "lru_victim_selector_core_assert.svh"

module lvs_checker
    import lvs_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic [FIDX_W-1:0]  i_rsp_frame,
    input logic               i_rsp_empty
);
    logic w_req_acc;
    logic w_rsp_stall;

    assign w_req_acc   = i_req_valid && i_req_ready;
    assign w_rsp_stall = i_rsp_valid && !i_rsp_ready;

    // a stalled result holds its payload
    `LVS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, w_rsp_stall, i_rsp_valid && $stable(i_rsp_frame) && $stable(i_rsp_empty), "stalled result changed")

    // every accepted transaction makes the block busy, so ready drops after the accept
    `LVS_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, w_req_acc, !i_req_ready, "ready right after accept")

    // a new result only comes out of the finish step
    `LVS_ASSERT_NOW(a_rsp_from_fin, i_clk, i_rst_n, $rose(i_rsp_valid), $past(!i_req_ready), "result without work")

    // reset leaves the block ready and empty
    `LVS_ASSERT_NEXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, i_req_ready && !i_rsp_valid, "bad state after reset")
endmodule

bind lru_victim_selector_core lvs_checker u_lvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_frame (o_rsp.payload.victim_frame),
    .i_rsp_empty (o_rsp.payload.was_empty)
);

/* tb/sv/tb_lru_victim_selector_core.sv */
`timescale 1ns / 100ps

module tb_lru_victim_selector_core;
    import lvs_pkg::*;

    localparam int          NUM_FRAMES    = 16;
    localparam int          CNT_W         = 16;
    localparam int          SETTLE_CYCLES = 24;        // outlasts one reference item
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ITEMS  = 1400;
    localparam int          NUM_PHASES    = 10;
    localparam int          AGE_REFS      = 120;       // frame 0 ends well below zero
    localparam int          MAX_REPORTS   = 10;

    // receiver stall patterns
    localparam int RX_ALWAYS = 0;
    localparam int RX_BURSTY = 1;
    localparam int RX_COIN   = 2;

    typedef logic signed [CNT_W-1:0] t_age;
    localparam t_age AGE_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [FIU_W-1:0]  cfg_wdata;

    lvs_chan_if #(.T(t_req)) req_if ();
    lvs_chan_if #(.T(t_rsp)) rsp_if ();

    lru_victim_selector_core #(
        .MAX_FRAMES (NUM_FRAMES),
        .COUNT_BITS (CNT_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the selector: frame-count register plus one signed
    // countdown per frame, updated when a request transaction is taken.
    // ------------------------------------------------------------------
    logic [FIU_W-1:0] frames_reg;
    t_age             age_cnt [NUM_FRAMES];
    t_rsp             victim_q [$];   // victims still owed by the DUT

    int unsigned      cycle_count    = 0;
    int               mismatch_count = 0;
    int               burst_left     = 0;
    bit               pacing_on      = 1'b1;

    // effective frame count: 0 acts as 1, anything above 16 acts as 16
    function automatic int frames_active();
        int n;
        n = int'(frames_reg);
        if (n == 0) n = 1;
        if (n > NUM_FRAMES) n = NUM_FRAMES;
        return n;
    endfunction

    function automatic void age_reset();
        frames_reg = FIU_W'(FIU_RESET);
        for (int i = 0; i < NUM_FRAMES; i++) age_cnt[i] = CNT_W'(frames_active());
    endfunction

    function automatic void apply_req(t_req r);
        int   n;
        int   pick;
        logic hit;
        t_rsp rsp;
        n = frames_active();
        if (r.opcode == OP_REFERENCE) begin
            // refresh only inside the count, but always age every frame in use
            if (int'(r.frame_index) < n) age_cnt[r.frame_index] = CNT_W'(n);
            for (int i = 0; i < n; i++) begin
                if (age_cnt[i] != AGE_MIN) age_cnt[i] = age_cnt[i] - CNT_W'(1);
            end
        end else begin
            // first empty frame wins; else oldest, lowest index on a tie
            pick = 0;
            hit  = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!hit) begin
                    if (r.empty_mask[i]) begin
                        pick = i;
                        hit  = 1'b1;
                    end else if (age_cnt[i] < age_cnt[pick]) begin
                        pick = i;
                    end
                end
            end
            age_cnt[pick]    = CNT_W'(n);
            rsp.victim_frame = FIDX_W'(pick);
            rsp.was_empty    = hit;
            victim_q.push_back(rsp);
        end
    endfunction

    function automatic t_req make_req(t_opcode op, int idx, logic [MASK_W-1:0] mask);
        t_req r;
        r.opcode      = op;
        r.frame_index = FIDX_W'(idx);
        r.empty_mask  = mask;
        return r;
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @ cycle %0d: %s", cycle_count, msg);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Bursts of random length, random gaps in between.
    // Inputs move on the falling edge; acceptance is seen on the rising.
    // ------------------------------------------------------------------
    task automatic send_req(t_req r);
        int gap;
        if (pacing_on && burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        req_if.valid   = 1'b1;
        req_if.payload = r;
        do @(posedge i_clk); while (!req_if.ready);
        apply_req(r);
    endtask

    // Register write only when idle: all victims back, and enough cycles
    // for a trailing reference (which returns nothing) to finish.
    task automatic write_frames(logic [FIU_W-1:0] value);
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge i_clk);
        frames_reg = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: the stall pattern is picked anew for each phase of random
    // length: always-ready, bursty stalls or a coin flip per cycle.
    // ------------------------------------------------------------------
    initial begin : rsp_stall_gen
        int mode;
        int stall_left;
        int phase_left;
        rsp_if.ready = 1'b0;
        mode         = RX_ALWAYS;
        stall_left   = 0;
        phase_left   = 0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                mode       = $urandom_range(RX_ALWAYS, RX_COIN);
                phase_left = $urandom_range(100, 400);
            end
            phase_left--;
            case (mode)
                RX_ALWAYS: begin
                    rsp_if.ready = 1'b1;
                end
                RX_BURSTY: begin
                    if (stall_left > 0) begin
                        rsp_if.ready = 1'b0;
                        stall_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        rsp_if.ready = 1'b0;
                        stall_left   = $urandom_range(0, 11);
                    end else begin
                        rsp_if.ready = 1'b1;
                    end
                end
                default: begin
                    rsp_if.ready = 1'($urandom_range(0, 1));
                end
            endcase
        end
    end

    // Every victim transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (victim_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected victim: frame %0d, was_empty %0b",
                                        rsp_if.payload.victim_frame,
                                        rsp_if.payload.was_empty));
            end else begin
                want = victim_q.pop_front();
                if (rsp_if.payload.victim_frame !== want.victim_frame)
                    flag_mismatch($sformatf("victim_frame expected %0d, actual %0d",
                                            want.victim_frame,
                                            rsp_if.payload.victim_frame));
                if (rsp_if.payload.was_empty !== want.was_empty)
                    flag_mismatch($sformatf("was_empty expected %0b, actual %0b",
                                            want.was_empty, rsp_if.payload.was_empty));
            end
        end
    end

    // hard stop if the DUT hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // after reset all countdowns are equal; lowest index wins the tie
    task automatic test_reset_state();
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
        send_req(make_req(OP_CHOOSE, 15, 16'hFFFF));
        send_req(make_req(OP_CHOOSE, 9, 16'h8000));
    endtask

    // references build up an age order that the choose must follow
    task automatic test_reference_order();
        send_req(make_req(OP_REFERENCE, 0, 16'hFFFF));
        send_req(make_req(OP_REFERENCE, 15, 16'h0000));
        send_req(make_req(OP_REFERENCE, 7, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'h0100));
        send_req(make_req(OP_REFERENCE, 3, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
    endtask

    // count of zero, count above range, references and empty bits
    // beyond the count
    task automatic test_frame_count();
        write_frames(5'd0);
        send_req(make_req(OP_CHOOSE, 0, 16'hFFFE));
        send_req(make_req(OP_CHOOSE, 0, 16'hFFFF));
        send_req(make_req(OP_REFERENCE, 5, 16'h0000));
        write_frames(5'd31);
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
        write_frames(5'd4);
        send_req(make_req(OP_REFERENCE, 9, 16'h0000));
        send_req(make_req(OP_REFERENCE, 12, 16'h0000));
        send_req(make_req(OP_REFERENCE, 2, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'hFFF0));
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'h0008));
    endtask

    // Two frames; frame 1 keeps getting refreshed while frame 0 ages far
    // below zero, so the signed compare has to keep it the oldest.
    task automatic test_long_aging();
        write_frames(5'd2);
        pacing_on = 1'b0;
        for (int k = 0; k < AGE_REFS; k++)
            send_req(make_req(OP_REFERENCE, (k % 64 == 0) ? 15 : 1, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
        send_req(make_req(OP_CHOOSE, 0, 16'h0000));
        pacing_on = 1'b1;
    endtask

    // random mix over several frame counts, extremes included
    task automatic test_random_traffic();
        logic [FIU_W-1:0] counts [NUM_PHASES];
        int               n;
        int               idx;
        logic [MASK_W-1:0] mask;
        counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd15, 5'd8, 5'd16, 5'd16};
        counts[8] = FIU_W'($urandom_range(0, 31));
        counts[9] = FIU_W'($urandom_range(1, 16));
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_frames(counts[p]);
            n = frames_active();
            for (int k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++) begin
                mask = MASK_W'($urandom());
                idx  = $urandom_range(0, 15);
                if ($urandom_range(0, 9) < 3) begin
                    // mostly no empty frame, so the age compare does the work
                    case ($urandom_range(0, 3))
                        0, 1:    mask = '0;
                        2:       mask = MASK_W'(1) << $urandom_range(0, 15);
                        default: ;
                    endcase
                    send_req(make_req(OP_CHOOSE, idx, mask));
                end else begin
                    if ($urandom_range(0, 7) != 0) idx = $urandom_range(0, n - 1);
                    send_req(make_req(OP_REFERENCE, idx, mask));
                end
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        age_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_reference_order();
        test_frame_count();
        test_long_aging();
        test_random_traffic();

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
